// ===== hdl/escu_pkg.sv =====
`default_nettype none

package escu_pkg;

  // Micro-operations of the compensation sequencer.
  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_ASR,
    OP_SHL,
    OP_CLAMP,
    OP_CHKZ,
    OP_WFINE,
    OP_OUTS,
    OP_OUTU,
    OP_RET
  } op_t;

  // Operand sources: scratch registers first, then fields and constants.
  typedef enum logic [5:0] {
    SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5, SRC_R6, SRC_R7,
    SRC_FINE,
    SRC_T1, SRC_T2, SRC_T3,
    SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
    SRC_H1, SRC_H2, SRC_H3, SRC_H4, SRC_H5, SRC_H6,
    SRC_ADCT, SRC_ADCP, SRC_ADCH,
    SRC_ONE, SRC_K5, SRC_K128, SRC_K128000, SRC_K3125, SRC_K1048576,
    SRC_K76800, SRC_K16384, SRC_K2097152, SRC_K8192, SRC_K32768
  } src_t;

  typedef struct packed {
    op_t        op;
    logic       w32;
    logic [2:0] dst;
    src_t       a;
    src_t       b;
    logic [5:0] sh;
  } instr_t;

  typedef logic [6:0] pc_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic   load;
    logic   issue;
    logic   fault;
    instr_t instr;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic zero;
    logic done;
  } stat_t;

  localparam pc_t ENTRY_FINE = 7'd0;
  localparam pc_t ENTRY_TEMP = 7'd14;
  localparam pc_t ENTRY_PRES = 7'd18;
  localparam pc_t ENTRY_HUM  = 7'd53;

  localparam logic [1:0] OPER_TEMP = 2'd0;
  localparam logic [1:0] OPER_PRES = 2'd1;
  localparam logic [1:0] OPER_HUM  = 2'd2;

  localparam logic [2:0] CFG_TEMP = 3'd0;
  localparam logic [2:0] CFG_PLO  = 3'd1;
  localparam logic [2:0] CFG_PHI  = 3'd2;
  localparam logic [2:0] CFG_MIX  = 3'd3;
  localparam logic [2:0] CFG_HUM  = 3'd4;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  function automatic instr_t mk(input op_t op, input logic w, input logic [2:0] d,
                                input src_t a, input src_t b, input logic [5:0] sh);
    instr_t i;
    i.op  = op;
    i.w32 = w;
    i.dst = d;
    i.a   = a;
    i.b   = b;
    i.sh  = sh;
    return i;
  endfunction

  // Microprogram: fine temperature update, then the three result programs.
  function automatic instr_t rom(input pc_t pc);
    instr_t i;
    case (pc)
      // Fine temperature, 32-bit wrap.
      7'd0:  i = mk(OP_ASR, 1'b1, 3'd0, SRC_ADCT, SRC_R0, 6'd3);
      7'd1:  i = mk(OP_SHL, 1'b1, 3'd1, SRC_T1, SRC_R0, 6'd1);
      7'd2:  i = mk(OP_SUB, 1'b1, 3'd0, SRC_R0, SRC_R1, 6'd0);
      7'd3:  i = mk(OP_MUL, 1'b1, 3'd0, SRC_R0, SRC_T2, 6'd0);
      7'd4:  i = mk(OP_ASR, 1'b1, 3'd0, SRC_R0, SRC_R0, 6'd11);
      7'd5:  i = mk(OP_ASR, 1'b1, 3'd1, SRC_ADCT, SRC_R0, 6'd4);
      7'd6:  i = mk(OP_SUB, 1'b1, 3'd1, SRC_R1, SRC_T1, 6'd0);
      7'd7:  i = mk(OP_MUL, 1'b1, 3'd1, SRC_R1, SRC_R1, 6'd0);
      7'd8:  i = mk(OP_ASR, 1'b1, 3'd1, SRC_R1, SRC_R0, 6'd12);
      7'd9:  i = mk(OP_MUL, 1'b1, 3'd1, SRC_R1, SRC_T3, 6'd0);
      7'd10: i = mk(OP_ASR, 1'b1, 3'd1, SRC_R1, SRC_R0, 6'd14);
      7'd11: i = mk(OP_ADD, 1'b1, 3'd0, SRC_R0, SRC_R1, 6'd0);
      7'd12: i = mk(OP_WFINE, 1'b1, 3'd0, SRC_R0, SRC_R0, 6'd0);
      7'd13: i = mk(OP_RET, 1'b0, 3'd0, SRC_R0, SRC_R0, 6'd0);
      // Temperature in hundredths of a degree.
      7'd14: i = mk(OP_MUL, 1'b1, 3'd0, SRC_FINE, SRC_K5, 6'd0);
      7'd15: i = mk(OP_ADD, 1'b1, 3'd0, SRC_R0, SRC_K128, 6'd0);
      7'd16: i = mk(OP_ASR, 1'b1, 3'd0, SRC_R0, SRC_R0, 6'd8);
      7'd17: i = mk(OP_OUTS, 1'b0, 3'd0, SRC_R0, SRC_R0, 6'd0);
      // Pressure, 64-bit wrap.
      7'd18: i = mk(OP_SUB, 1'b0, 3'd0, SRC_FINE, SRC_K128000, 6'd0);
      7'd19: i = mk(OP_MUL, 1'b0, 3'd1, SRC_R0, SRC_R0, 6'd0);
      7'd20: i = mk(OP_MUL, 1'b0, 3'd2, SRC_R1, SRC_P6, 6'd0);
      7'd21: i = mk(OP_MUL, 1'b0, 3'd3, SRC_R0, SRC_P5, 6'd0);
      7'd22: i = mk(OP_SHL, 1'b0, 3'd3, SRC_R3, SRC_R0, 6'd17);
      7'd23: i = mk(OP_ADD, 1'b0, 3'd2, SRC_R2, SRC_R3, 6'd0);
      7'd24: i = mk(OP_SHL, 1'b0, 3'd3, SRC_P4, SRC_R0, 6'd35);
      7'd25: i = mk(OP_ADD, 1'b0, 3'd2, SRC_R2, SRC_R3, 6'd0);
      7'd26: i = mk(OP_MUL, 1'b0, 3'd1, SRC_R1, SRC_P3, 6'd0);
      7'd27: i = mk(OP_ASR, 1'b0, 3'd1, SRC_R1, SRC_R0, 6'd8);
      7'd28: i = mk(OP_MUL, 1'b0, 3'd3, SRC_R0, SRC_P2, 6'd0);
      7'd29: i = mk(OP_SHL, 1'b0, 3'd3, SRC_R3, SRC_R0, 6'd12);
      7'd30: i = mk(OP_ADD, 1'b0, 3'd1, SRC_R1, SRC_R3, 6'd0);
      7'd31: i = mk(OP_SHL, 1'b0, 3'd3, SRC_ONE, SRC_R0, 6'd47);
      7'd32: i = mk(OP_ADD, 1'b0, 3'd1, SRC_R3, SRC_R1, 6'd0);
      7'd33: i = mk(OP_MUL, 1'b0, 3'd1, SRC_R1, SRC_P1, 6'd0);
      7'd34: i = mk(OP_ASR, 1'b0, 3'd1, SRC_R1, SRC_R0, 6'd33);
      7'd35: i = mk(OP_CHKZ, 1'b0, 3'd0, SRC_R1, SRC_R0, 6'd0);
      7'd36: i = mk(OP_SUB, 1'b0, 3'd0, SRC_K1048576, SRC_ADCP, 6'd0);
      7'd37: i = mk(OP_SHL, 1'b0, 3'd0, SRC_R0, SRC_R0, 6'd31);
      7'd38: i = mk(OP_SUB, 1'b0, 3'd0, SRC_R0, SRC_R2, 6'd0);
      7'd39: i = mk(OP_MUL, 1'b0, 3'd0, SRC_R0, SRC_K3125, 6'd0);
      7'd40: i = mk(OP_DIV, 1'b0, 3'd0, SRC_R0, SRC_R1, 6'd0);
      7'd41: i = mk(OP_ASR, 1'b0, 3'd3, SRC_R0, SRC_R0, 6'd13);
      7'd42: i = mk(OP_MUL, 1'b0, 3'd4, SRC_P9, SRC_R3, 6'd0);
      7'd43: i = mk(OP_MUL, 1'b0, 3'd4, SRC_R4, SRC_R3, 6'd0);
      7'd44: i = mk(OP_ASR, 1'b0, 3'd4, SRC_R4, SRC_R0, 6'd25);
      7'd45: i = mk(OP_MUL, 1'b0, 3'd5, SRC_P8, SRC_R0, 6'd0);
      7'd46: i = mk(OP_ASR, 1'b0, 3'd5, SRC_R5, SRC_R0, 6'd19);
      7'd47: i = mk(OP_ADD, 1'b0, 3'd0, SRC_R0, SRC_R4, 6'd0);
      7'd48: i = mk(OP_ADD, 1'b0, 3'd0, SRC_R0, SRC_R5, 6'd0);
      7'd49: i = mk(OP_ASR, 1'b0, 3'd0, SRC_R0, SRC_R0, 6'd8);
      7'd50: i = mk(OP_SHL, 1'b0, 3'd6, SRC_P7, SRC_R0, 6'd4);
      7'd51: i = mk(OP_ADD, 1'b0, 3'd0, SRC_R0, SRC_R6, 6'd0);
      7'd52: i = mk(OP_OUTU, 1'b0, 3'd0, SRC_R0, SRC_R0, 6'd0);
      // Humidity, 32-bit wrap.
      7'd53: i = mk(OP_SUB, 1'b1, 3'd0, SRC_FINE, SRC_K76800, 6'd0);
      7'd54: i = mk(OP_SHL, 1'b1, 3'd1, SRC_ADCH, SRC_R0, 6'd14);
      7'd55: i = mk(OP_SHL, 1'b1, 3'd2, SRC_H4, SRC_R0, 6'd20);
      7'd56: i = mk(OP_SUB, 1'b1, 3'd1, SRC_R1, SRC_R2, 6'd0);
      7'd57: i = mk(OP_MUL, 1'b1, 3'd2, SRC_H5, SRC_R0, 6'd0);
      7'd58: i = mk(OP_SUB, 1'b1, 3'd1, SRC_R1, SRC_R2, 6'd0);
      7'd59: i = mk(OP_ADD, 1'b1, 3'd1, SRC_R1, SRC_K16384, 6'd0);
      7'd60: i = mk(OP_ASR, 1'b1, 3'd1, SRC_R1, SRC_R0, 6'd15);
      7'd61: i = mk(OP_MUL, 1'b1, 3'd2, SRC_R0, SRC_H6, 6'd0);
      7'd62: i = mk(OP_ASR, 1'b1, 3'd2, SRC_R2, SRC_R0, 6'd10);
      7'd63: i = mk(OP_MUL, 1'b1, 3'd3, SRC_R0, SRC_H3, 6'd0);
      7'd64: i = mk(OP_ASR, 1'b1, 3'd3, SRC_R3, SRC_R0, 6'd11);
      7'd65: i = mk(OP_ADD, 1'b1, 3'd3, SRC_R3, SRC_K32768, 6'd0);
      7'd66: i = mk(OP_MUL, 1'b1, 3'd2, SRC_R2, SRC_R3, 6'd0);
      7'd67: i = mk(OP_ASR, 1'b1, 3'd2, SRC_R2, SRC_R0, 6'd10);
      7'd68: i = mk(OP_ADD, 1'b1, 3'd2, SRC_R2, SRC_K2097152, 6'd0);
      7'd69: i = mk(OP_MUL, 1'b1, 3'd2, SRC_R2, SRC_H2, 6'd0);
      7'd70: i = mk(OP_ADD, 1'b1, 3'd2, SRC_R2, SRC_K8192, 6'd0);
      7'd71: i = mk(OP_ASR, 1'b1, 3'd2, SRC_R2, SRC_R0, 6'd14);
      7'd72: i = mk(OP_MUL, 1'b1, 3'd0, SRC_R1, SRC_R2, 6'd0);
      7'd73: i = mk(OP_ASR, 1'b1, 3'd1, SRC_R0, SRC_R0, 6'd15);
      7'd74: i = mk(OP_MUL, 1'b1, 3'd1, SRC_R1, SRC_R1, 6'd0);
      7'd75: i = mk(OP_ASR, 1'b1, 3'd1, SRC_R1, SRC_R0, 6'd7);
      7'd76: i = mk(OP_MUL, 1'b1, 3'd1, SRC_R1, SRC_H1, 6'd0);
      7'd77: i = mk(OP_ASR, 1'b1, 3'd1, SRC_R1, SRC_R0, 6'd4);
      7'd78: i = mk(OP_SUB, 1'b1, 3'd0, SRC_R0, SRC_R1, 6'd0);
      7'd79: i = mk(OP_CLAMP, 1'b0, 3'd0, SRC_R0, SRC_R0, 6'd0);
      7'd80: i = mk(OP_OUTU, 1'b0, 3'd0, SRC_R0, SRC_R0, 6'd0);
      default: i = mk(OP_OUTU, 1'b0, 3'd0, SRC_R0, SRC_R0, 6'd0);
    endcase
    return i;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/escu_ram.sv =====
`default_nettype none

module escu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/escu_dp.sv =====
`default_nettype none

module escu_dp import escu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic [19:0] raw_measurement_in,
  input  wire logic [19:0] raw_temperature_in,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output logic      [32:0] value,
  output logic             status
);

  logic [47:0] cal_temp;
  logic [63:0] cal_plo;
  logic [63:0] cal_phi;
  logic [47:0] cal_mix;
  logic [31:0] cal_hum;
  logic [31:0] fine;
  logic [19:0] raw_meas;
  logic [19:0] raw_temp;

  logic [63:0] rdata_a;
  logic [63:0] rdata_b;
  logic        rf_we;
  logic [2:0]  rf_waddr;
  logic [63:0] rf_wdata;

  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] alu;
  logic [63:0] alu_w;
  logic [31:0] clamp_v;
  logic        alu_write;

  // Multiplier state.
  logic        mbusy;
  logic [1:0]  mstep;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] macc;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] mprod;
  logic [63:0] mfinal;
  logic        mfin;

  // Divider state.
  logic        dbusy;
  logic [5:0]  dcnt;
  logic        dneg;
  logic [63:0] dquo;
  logic [63:0] drem;
  logic [63:0] ddvs;
  logic [64:0] dshift;
  logic [64:0] ddiff;
  logic [63:0] drem_next;
  logic [63:0] dquo_next;
  logic [63:0] dres;
  logic        dfin;

  // Result routing for long operations.
  logic [2:0]  ldst;
  logic        lw32;
  logic [63:0] lres;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx12(input logic [11:0] v);
    return {{52{v[11]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] src_val(input src_t s, input logic [63:0] rv);
    logic [63:0] v;
    case (s)
      SRC_FINE:     v = sx32(fine);
      SRC_T1:       v = {48'b0, cal_temp[15:0]};
      SRC_T2:       v = sx16(cal_temp[31:16]);
      SRC_T3:       v = sx16(cal_temp[47:32]);
      SRC_P1:       v = {48'b0, cal_plo[15:0]};
      SRC_P2:       v = sx16(cal_plo[31:16]);
      SRC_P3:       v = sx16(cal_plo[47:32]);
      SRC_P4:       v = sx16(cal_plo[63:48]);
      SRC_P5:       v = sx16(cal_phi[15:0]);
      SRC_P6:       v = sx16(cal_phi[31:16]);
      SRC_P7:       v = sx16(cal_phi[47:32]);
      SRC_P8:       v = sx16(cal_phi[63:48]);
      SRC_P9:       v = sx16(cal_mix[15:0]);
      SRC_H1:       v = {56'b0, cal_mix[23:16]};
      SRC_H2:       v = sx16(cal_mix[39:24]);
      SRC_H3:       v = {56'b0, cal_mix[47:40]};
      SRC_H4:       v = sx12(cal_hum[11:0]);
      SRC_H5:       v = sx12(cal_hum[23:12]);
      SRC_H6:       v = {{56{cal_hum[31]}}, cal_hum[31:24]};
      SRC_ADCT:     v = {44'b0, raw_temp};
      SRC_ADCP:     v = {44'b0, raw_meas};
      SRC_ADCH:     v = {48'b0, raw_meas[15:0]};
      SRC_ONE:      v = 64'd1;
      SRC_K5:       v = 64'd5;
      SRC_K128:     v = 64'd128;
      SRC_K128000:  v = 64'd128000;
      SRC_K3125:    v = 64'd3125;
      SRC_K1048576: v = 64'd1048576;
      SRC_K76800:   v = 64'd76800;
      SRC_K16384:   v = 64'd16384;
      SRC_K2097152: v = 64'd2097152;
      SRC_K8192:    v = 64'd8192;
      SRC_K32768:   v = 64'd32768;
      default:      v = rv;
    endcase
    return v;
  endfunction

  escu_ram #(
    .WIDTH(64),
    .DEPTH(8)
  ) u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .raddr_a (cmd.instr.a[2:0]),
    .raddr_b (cmd.instr.b[2:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Calibration registers and the fine temperature.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp <= '0;
      cal_plo  <= '0;
      cal_phi  <= '0;
      cal_mix  <= '0;
      cal_hum  <= '0;
      fine     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TEMP: cal_temp <= cfg_data[47:0];
          CFG_PLO:  cal_plo  <= cfg_data;
          CFG_PHI:  cal_phi  <= cfg_data;
          CFG_MIX:  cal_mix  <= cfg_data[47:0];
          CFG_HUM:  cal_hum  <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (cmd.issue && cmd.instr.op == OP_WFINE) begin
        fine <= opa[31:0];
      end
    end
  end

  // Raw readings are captured with the transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_meas <= raw_measurement_in;
      raw_temp <= raw_temperature_in;
    end
  end

  assign opa = src_val(cmd.instr.a, rdata_a);
  assign opb = src_val(cmd.instr.b, rdata_b);

  // Combinational ALU operations.
  always_comb begin
    clamp_v = opa[31:0];
    if (clamp_v[31]) begin
      clamp_v = '0;
    end else if (clamp_v > HUM_MAX) begin
      clamp_v = HUM_MAX;
    end
    case (cmd.instr.op)
      OP_ADD:   alu = opa + opb;
      OP_SUB:   alu = opa - opb;
      OP_ASR:   alu = $signed(opa) >>> cmd.instr.sh;
      OP_SHL:   alu = opa << cmd.instr.sh;
      OP_CLAMP: alu = {44'b0, clamp_v[31:12]};
      default:  alu = opa;
    endcase
    alu_w = cmd.instr.w32 ? sx32(alu[31:0]) : alu;
    alu_write = cmd.issue && (cmd.instr.op == OP_ADD || cmd.instr.op == OP_SUB ||
                              cmd.instr.op == OP_ASR || cmd.instr.op == OP_SHL ||
                              cmd.instr.op == OP_CLAMP);
  end

  // Shared 32x32 multiplier: low 64 bits of a 64x64 product in three steps.
  assign mx     = (mstep == 2'd2) ? ma[63:32] : ma[31:0];
  assign my     = (mstep == 2'd1) ? mb[63:32] : mb[31:0];
  assign mprod  = {32'b0, mx} * {32'b0, my};
  assign mfinal = macc + {mprod[31:0], 32'b0};
  assign mfin   = mbusy && mstep == 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mstep <= '0;
    end else if (cmd.issue && cmd.instr.op == OP_MUL) begin
      mbusy <= 1'b1;
      mstep <= '0;
    end else if (mbusy) begin
      mstep <= mstep + 2'd1;
      if (mfin) begin
        mbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue && cmd.instr.op == OP_MUL) begin
      ma <= opa;
      mb <= opb;
    end else if (mbusy) begin
      macc <= (mstep == 2'd0) ? mprod : mfinal;
    end
  end

  // Restoring signed divider, one quotient bit a cycle.
  assign dshift    = {drem, dquo[63]};
  assign ddiff     = dshift - {1'b0, ddvs};
  assign drem_next = ddiff[64] ? dshift[63:0] : ddiff[63:0];
  assign dquo_next = {dquo[62:0], ~ddiff[64]};
  assign dres      = dneg ? (64'd0 - dquo_next) : dquo_next;
  assign dfin      = dbusy && dcnt == 6'd63;

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (cmd.issue && cmd.instr.op == OP_DIV) begin
      dbusy <= 1'b1;
      dcnt  <= '0;
    end else if (dbusy) begin
      dcnt <= dcnt + 6'd1;
      if (dfin) begin
        dbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue && cmd.instr.op == OP_DIV) begin
      dneg <= opa[63] ^ opb[63];
      dquo <= opa[63] ? (64'd0 - opa) : opa;
      ddvs <= opb[63] ? (64'd0 - opb) : opb;
      drem <= '0;
    end else if (dbusy) begin
      dquo <= dquo_next;
      drem <= drem_next;
    end
  end

  // Destination of a long operation.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ldst <= cmd.instr.dst;
      lw32 <= cmd.instr.w32;
    end
  end

  // Register file write from either the ALU or a long operation.
  always_comb begin
    lres     = mfin ? mfinal : dres;
    rf_we    = alu_write || mfin || dfin;
    rf_waddr = alu_write ? cmd.instr.dst : ldst;
    if (alu_write) begin
      rf_wdata = alu_w;
    end else begin
      rf_wdata = lw32 ? sx32(lres[31:0]) : lres;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.fault) begin
      value  <= '0;
      status <= 1'b1;
    end else if (cmd.issue && cmd.instr.op == OP_OUTS) begin
      value  <= opa[32:0];
      status <= 1'b0;
    end else if (cmd.issue && cmd.instr.op == OP_OUTU) begin
      value  <= {1'b0, opa[31:0]};
      status <= 1'b0;
    end
  end

  assign stat.zero = (opa == 64'd0);
  assign stat.done = mfin || dfin;

endmodule

`default_nettype wire

// ===== hdl/escu_ctrl.sv =====
`default_nettype none

module escu_ctrl import escu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] operation,
  input  wire logic       update_temperature,
  output logic            out_valid,
  input  wire logic       out_ready,
  output cmd_t            cmd,
  input  wire stat_t      stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  pc_t    pc;
  pc_t    pc_next;
  pc_t    ret_pc;
  pc_t    ret_pc_next;
  pc_t    entry;
  logic   out_set;
  logic   out_free;
  instr_t instr;

  assign instr    = rom(pc);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Program chosen by the operation of the incoming transfer.
  always_comb begin
    case (operation)
      OPER_PRES: entry = ENTRY_PRES;
      OPER_HUM:  entry = ENTRY_HUM;
      default:   entry = ENTRY_TEMP;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next  = state;
    pc_next     = pc;
    ret_pc_next = ret_pc;
    out_set     = 1'b0;
    cmd.load    = 1'b0;
    cmd.issue   = 1'b0;
    cmd.fault   = 1'b0;
    cmd.instr   = instr;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
          if (update_temperature || entry == ENTRY_TEMP) begin
            pc_next     = ENTRY_FINE;
            ret_pc_next = entry;
          end else begin
            pc_next = entry;
          end
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        case (instr.op)
          OP_MUL, OP_DIV: begin
            cmd.issue  = 1'b1;
            state_next = S_WAIT;
          end
          OP_OUTS, OP_OUTU: begin
            if (out_free) begin
              cmd.issue  = 1'b1;
              out_set    = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_CHKZ: begin
            if (!stat.zero) begin
              pc_next    = pc + 7'd1;
              state_next = S_READ;
            end else if (out_free) begin
              cmd.fault  = 1'b1;
              out_set    = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_RET: begin
            pc_next    = ret_pc;
            state_next = S_READ;
          end
          default: begin
            cmd.issue  = 1'b1;
            pc_next    = pc + 7'd1;
            state_next = S_READ;
          end
        endcase
      end
      S_WAIT: begin
        if (stat.done) begin
          pc_next    = pc + 7'd1;
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= ENTRY_FINE;
      ret_pc    <= ENTRY_TEMP;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      ret_pc <= ret_pc_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/environment_sensor_compensation_unit.sv =====
// Integer compensation of raw temperature, pressure and humidity readings with
// calibration words that the user must write through the cfg port only while
// the unit is idle; the block itself does not enforce this. A
// microprogrammed sequencer drives a 64-bit datapath with an eight-entry scratch
// register file, one 32x32 multiplier that sums partial products into each
// 64-bit product and a one-bit-per-cycle signed divider. Each micro-operation
// passes an operand-read state and an execute state; a multiply or divide adds
// a wait state. The fine temperature is refreshed first for a temperature item
// or when update_temperature is set. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted.
`default_nettype none

module environment_sensor_compensation_unit import escu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // raw_measurement[19:0], raw_temperature[39:20]
  input  wire logic [39:0] s_axis_tdata,
  // operation[1:0], update_temperature[2]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // compensated_value[32:0], zero fill [39:33]
  output logic      [39:0] m_axis_tdata,
  // status[0]
  output logic             m_axis_tuser,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cmd_t        cmd;
  stat_t       stat;
  logic [32:0] value;

  escu_ctrl u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (s_axis_tvalid),
    .in_ready           (s_axis_tready),
    .operation          (s_axis_tuser[1:0]),
    .update_temperature (s_axis_tuser[2]),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .cmd                (cmd),
    .stat               (stat)
  );

  escu_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .raw_measurement_in (s_axis_tdata[19:0]),
    .raw_temperature_in (s_axis_tdata[39:20]),
    .cmd                (cmd),
    .stat               (stat),
    .value              (value),
    .status             (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, value};

endmodule

`default_nettype wire

// ===== hdl/escu_checker.sv =====
`default_nettype none

module escu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A held result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A held result keeps its data.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The unit is busy right after taking an item.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !$rose(m_axis_tvalid))
    else $error("item accepted or finished too early");

  // A zero pressure divisor reports a zero value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
    else $error("fault status with nonzero value");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind environment_sensor_compensation_unit escu_checker u_escu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
